// ----- design/retry_backoff_scheduler_top_assert.svh -----
// ----------------------------------------------------------------------------
// retry_backoff_scheduler_top_assert.svh
// Assertion macros for the retry backoff scheduler.
// ----------------------------------------------------------------------------
`ifndef RETRY_BACKOFF_SCHEDULER_TOP_ASSERT_SVH
`define RETRY_BACKOFF_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define RBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rbs assertion failed");
// checked during reset as well
`define RBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rbs assertion failed");
`else
`define RBS_ASSERT(lbl, clk, rst_n, prop)
`define RBS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the retry backoff scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

    localparam int DELAY_W  = 16;
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 3;
    localparam int KIND_W   = 2;
    localparam int CFG_AW   = 3;
    localparam int NUM_STEP = 5;

    // event kinds
    localparam logic [KIND_W-1:0] REQ_POLL    = 2'd0;
    localparam logic [KIND_W-1:0] REQ_FAILURE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_SUCCESS = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_DELAY0 = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_DELAY1 = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_DELAY2 = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DELAY3 = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DELAY4 = 3'd4;

    localparam logic [DELAY_W-1:0] DELAY0_RST = 16'd15;
    localparam logic [DELAY_W-1:0] DELAY1_RST = 16'd30;
    localparam logic [DELAY_W-1:0] DELAY2_RST = 16'd60;
    localparam logic [DELAY_W-1:0] DELAY3_RST = 16'd120;
    localparam logic [DELAY_W-1:0] DELAY4_RST = 16'd300;

    localparam logic [LEVEL_W-1:0] LEVEL_CAP = 3'd4;

    // delay * 1000 fits in 26 bits
    localparam int PROD_W = DELAY_W + 10;

    typedef logic [NUM_STEP-1:0][DELAY_W-1:0] delay_arr_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  next_ms;
    } sched_state_t;

    typedef struct packed {
        logic               ready;
        logic [DELAY_W-1:0] delay;
    } sched_result_t;

endpackage

`default_nettype wire

// ----- design/rbs_step.sv -----
// ----------------------------------------------------------------------------
// rbs_step
// Per-event logic: readiness check, delay select and schedule update.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_step (
    input  wire logic [rbs_pkg::KIND_W-1:0] kind,
    input  wire logic [rbs_pkg::TIME_W-1:0] now_ms,
    input  wire rbs_pkg::delay_arr_t        delays,
    input  wire rbs_pkg::sched_state_t      state_cur,
    output rbs_pkg::sched_state_t           state_nxt,
    output rbs_pkg::sched_result_t          result
);

    logic [rbs_pkg::TIME_W-1:0]  diff;
    logic [rbs_pkg::LEVEL_W-1:0] lvl;
    logic [rbs_pkg::DELAY_W-1:0] sel_delay;
    logic [rbs_pkg::PROD_W-1:0]  delay_ms;

    assign diff = now_ms - state_cur.next_ms;

    assign lvl = (state_cur.level > rbs_pkg::LEVEL_CAP) ? rbs_pkg::LEVEL_CAP
                                                        : state_cur.level;

    always_comb begin
        unique case (lvl)
            3'd0:    sel_delay = delays[0];
            3'd1:    sel_delay = delays[1];
            3'd2:    sel_delay = delays[2];
            3'd3:    sel_delay = delays[3];
            default: sel_delay = delays[4];
        endcase
    end

    // x*1000 = x*1024 - x*16 - x*8
    assign delay_ms = {sel_delay, 10'b0}
                    - {6'b0, sel_delay, 4'b0}
                    - {7'b0, sel_delay, 3'b0};

    always_comb begin
        state_nxt     = state_cur;
        result.ready  = ~diff[rbs_pkg::TIME_W-1];
        result.delay  = '0;
        unique case (kind)
            rbs_pkg::REQ_FAILURE: begin
                result.delay      = sel_delay;
                state_nxt.level   = (lvl < rbs_pkg::LEVEL_CAP) ? lvl + 3'd1 : lvl;
                state_nxt.next_ms = now_ms
                                  + {{(rbs_pkg::TIME_W-rbs_pkg::PROD_W){1'b0}}, delay_ms};
            end
            rbs_pkg::REQ_SUCCESS: begin
                state_nxt.level   = '0;
                state_nxt.next_ms = now_ms;
            end
            default: begin
                // poll and the unused kind leave the schedule alone
                state_nxt = state_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/retry_backoff_scheduler_top.sv -----
// Throughput: one word per cycle while m_tready does not stall the output.
// An accepted word passes the input register, then the schedule update
// and result register before its result is valid, with state fed back.
// Backpressure from m_tready reaches s_tready through the two stage enables.
// Reset (aresetn low, synchronous): level 0, next attempt 0, delay
// registers back to 15/30/60/120/300 s, both stages empty.
// ----------------------------------------------------------------------------
// retry_backoff_scheduler_top
// Capped backoff retry timer with configurable per-level delays.
// ----------------------------------------------------------------------------
`default_nettype none
`include "retry_backoff_scheduler_top_assert.svh"

module retry_backoff_scheduler_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // config write port
    input  wire logic                        cfg_we,
    input  wire logic [rbs_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [rbs_pkg::DELAY_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // [31:0] now_ms
    input  wire logic [1:0]                  s_tuser,   // [1:0] req_type
    // result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata    // [0] ready_res,
                                                        // [16:1] delay_seconds,
                                                        // [23:17] zero
);

    rbs_pkg::delay_arr_t delay_reg;

    logic                        in_valid_reg;
    logic [rbs_pkg::KIND_W-1:0]  in_kind_reg;
    logic [rbs_pkg::TIME_W-1:0]  in_now_reg;

    logic                        out_valid_reg;
    rbs_pkg::sched_result_t      out_res_reg;

    rbs_pkg::sched_state_t       state_reg;
    rbs_pkg::sched_state_t       state_next;
    rbs_pkg::sched_result_t      res_next;

    logic out_adv;
    logic step;
    logic s_accept;

    assign out_adv  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;
    assign s_accept = s_tvalid && s_tready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg[0] <= rbs_pkg::DELAY0_RST;
            delay_reg[1] <= rbs_pkg::DELAY1_RST;
            delay_reg[2] <= rbs_pkg::DELAY2_RST;
            delay_reg[3] <= rbs_pkg::DELAY3_RST;
            delay_reg[4] <= rbs_pkg::DELAY4_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rbs_pkg::CFG_DELAY0: delay_reg[0] <= cfg_wdata;
                rbs_pkg::CFG_DELAY1: delay_reg[1] <= cfg_wdata;
                rbs_pkg::CFG_DELAY2: delay_reg[2] <= cfg_wdata;
                rbs_pkg::CFG_DELAY3: delay_reg[3] <= cfg_wdata;
                rbs_pkg::CFG_DELAY4: delay_reg[4] <= cfg_wdata;
                default: ;  // writes past the last register are dropped
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg <= s_tuser;
            in_now_reg  <= s_tdata;
        end
    end

    rbs_step u_step (
        .kind      (in_kind_reg),
        .now_ms    (in_now_reg),
        .delays    (delay_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    // schedule state and result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                state_reg <= state_next;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_res_reg.delay, out_res_reg.ready};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `RBS_ASSERT(a_level_capped, aclk, aresetn, state_reg.level <= rbs_pkg::LEVEL_CAP)

    `RBS_ASSERT(a_success_clears, aclk, aresetn, (step && in_kind_reg == rbs_pkg::REQ_SUCCESS) |=> (state_reg.level == '0 && state_reg.next_ms == $past(in_now_reg)))

    `RBS_ASSERT(a_poll_holds, aclk, aresetn, (step && in_kind_reg != rbs_pkg::REQ_FAILURE && in_kind_reg != rbs_pkg::REQ_SUCCESS) |=> $stable(state_reg))

    `RBS_ASSERT(a_no_delay_unless_fail, aclk, aresetn, (step && in_kind_reg != rbs_pkg::REQ_FAILURE) |=> (out_res_reg.delay == '0))

    `RBS_ASSERT_ALWAYS(a_stall_only_when_full, aclk, !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))

endmodule

`default_nettype wire
